### hw/rtl/pbba_pkg.sv
package pbba_pkg;

  // Field widths of the item and result transfers
  localparam int JOINT_W  = 6;
  localparam int BONE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int POS_F_W  = 32;
  localparam int EXT_W    = 31;

  // Default sizing
  localparam int BONE_SLOTS_DEF = 64;
  localparam int MAP_SLOTS_DEF  = 64;
  localparam int POS_BITS_DEF   = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_SET    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic [JOINT_W-1:0]          joint_index;
    logic [BONE_W-1:0]           bone_id;
    logic signed [WEIGHT_W-1:0]  weight;
    logic signed [POS_F_W-1:0]   pos_x;
    logic signed [POS_F_W-1:0]   pos_y;
    logic signed [POS_F_W-1:0]   pos_z;
  } item_t;

  typedef struct packed {
    logic [BONE_W-1:0]          out_bone;
    logic signed [POS_F_W-1:0]  center_x;
    logic signed [POS_F_W-1:0]  center_y;
    logic signed [POS_F_W-1:0]  center_z;
    logic [EXT_W-1:0]           extent_x;
    logic [EXT_W-1:0]           extent_y;
    logic [EXT_W-1:0]           extent_z;
    logic                       is_last;
    logic                       is_empty;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cap_add;       // capture add item, read map slot
    logic map_write;     // write map slot
    logic map_clear;     // drop all map entries
    logic box_read_add;  // read box of the mapped bone
    logic box_write;     // write widened box
    logic scan_start;    // begin finish walk at bone 1
    logic scan_step;     // advance walk
    logic scan_read;     // read box at walk index
    logic pend_load;     // move fresh result to pending, emit old pending
    logic push_final;    // emit last or empty result
    logic touched_clear; // drop all boxes
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic add_ok;
    logic scan_hit;
    logic scan_end;
    logic out_free;
    logic pend_v;
  } ctrl_sts_t;

endpackage

### hw/rtl/pbba_ctrl.sv
module pbba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  pbba_pkg::cmd_t      item_cmd,
  output logic                item_ready,
  input  pbba_pkg::ctrl_sts_t sts,
  output pbba_pkg::ctrl_cmd_t ctl
);
  import pbba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAP   = 6'b000010,
    S_BOX   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FETCH = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  // Sequence commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          unique case (item_cmd)
            CMD_ADD: begin
              ctl.cap_add = 1'b1;
              state_next  = S_MAP;
            end
            CMD_SET:   ctl.map_write = 1'b1;
            CMD_CLEAR: ctl.map_clear = 1'b1;
            CMD_FINISH: begin
              ctl.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MAP: begin
        if (sts.add_ok) begin
          ctl.box_read_add = 1'b1;
          state_next       = S_BOX;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_BOX: begin
        ctl.box_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_SCAN: begin
        priority if (sts.scan_hit) begin
          ctl.scan_read = 1'b1;
          state_next    = S_FETCH;
        end else if (sts.scan_end) begin
          state_next = S_FLUSH;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_FETCH: begin
        if (!sts.pend_v || sts.out_free) begin
          ctl.pend_load = 1'b1;
          if (sts.scan_end) begin
            state_next = S_FLUSH;
          end else begin
            ctl.scan_step = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          ctl.push_final    = 1'b1;
          ctl.touched_clear = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_box_after_map: assert property (@(posedge clk) disable iff (rst)
    (state == S_BOX) |-> ($past(state) == S_MAP))
    else $error("box update without map lookup");

  a_fetch_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) && ($past(state) != S_FETCH) |-> ($past(state) == S_SCAN))
    else $error("box fetch not started by walk");

endmodule

### hw/rtl/pbba_datapath.sv
module pbba_datapath #(
  parameter int BONE_SLOTS = pbba_pkg::BONE_SLOTS_DEF,
  parameter int MAP_SLOTS  = pbba_pkg::MAP_SLOTS_DEF,
  parameter int POS_BITS   = pbba_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pbba_pkg::item_t     item,
  input  pbba_pkg::ctrl_cmd_t ctl,
  output pbba_pkg::ctrl_sts_t sts,
  output pbba_pkg::result_t   result,
  output logic                result_valid,
  input  logic                result_ready
);
  import pbba_pkg::*;

  localparam int POS_W     = (POS_BITS < POS_F_W) ? POS_BITS : POS_F_W;
  localparam int BOX_W     = 6 * POS_W;
  localparam int JOINT_MAX = 1 << JOINT_W;
  localparam int MAP_DEPTH = (MAP_SLOTS < JOINT_MAX) ? MAP_SLOTS : JOINT_MAX;
  localparam int MAP_IW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int BONE_IW   = $clog2(BONE_SLOTS);

  // Map store
  logic [BONE_IW-1:0]   map_mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] map_valid;
  logic [BONE_IW-1:0]   map_rd;
  logic                 map_hit_q;

  // Box store, min per axis in the low half, max in the high half
  logic [BOX_W-1:0]      box_mem [BONE_SLOTS];
  logic [BOX_W-1:0]      box_rd;
  logic [BOX_W-1:0]      box_wdata;
  logic [BONE_IW-1:0]    box_addr;
  logic [BONE_SLOTS-1:0] touched;

  logic signed [POS_W-1:0] pos_q [3];
  logic signed [POS_W-1:0] pos_in [3];

  logic [BONE_IW-1:0] scan_b;
  result_t            pend;
  logic               pend_v;
  result_t            fresh;
  result_t            final_res;

  logic               slot_ok;
  logic               weight_pos;
  logic [MAP_IW-1:0]  map_idx;

  // Decode the incoming item
  assign slot_ok    = (32'(item.joint_index) < MAP_DEPTH);
  assign weight_pos = !item.weight[WEIGHT_W-1] && (item.weight != '0);
  assign map_idx    = slot_ok ? item.joint_index[MAP_IW-1:0] : '0;
  assign pos_in[0]  = $signed(item.pos_x[POS_W-1:0]);
  assign pos_in[1]  = $signed(item.pos_y[POS_W-1:0]);
  assign pos_in[2]  = $signed(item.pos_z[POS_W-1:0]);

  // Map memory: write on set, registered read on add
  always_ff @(posedge clk) begin
    if (ctl.map_write && slot_ok && (32'(item.bone_id) < BONE_SLOTS)) begin
      map_mem[map_idx] <= item.bone_id[BONE_IW-1:0];
    end
    if (ctl.cap_add) begin
      map_rd <= map_mem[map_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
    end else if (ctl.map_clear) begin
      map_valid <= '0;
    end else if (ctl.map_write && slot_ok && (32'(item.bone_id) < BONE_SLOTS)) begin
      map_valid[map_idx] <= 1'b1;
    end
  end

  // Capture the add item
  always_ff @(posedge clk) begin
    if (ctl.cap_add) begin
      map_hit_q <= weight_pos && slot_ok && map_valid[map_idx];
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= pos_in[k];
      end
    end
  end

  // Widen the box, or seed it on first touch
  always_comb begin
    logic signed [POS_W-1:0] mn;
    logic signed [POS_W-1:0] mx;
    box_wdata = '0;
    for (int k = 0; k < 3; k++) begin
      mn = $signed(box_rd[k*POS_W +: POS_W]);
      mx = $signed(box_rd[(3+k)*POS_W +: POS_W]);
      if (!touched[map_rd] || (pos_q[k] < mn)) begin
        mn = pos_q[k];
      end
      if (!touched[map_rd] || (pos_q[k] > mx)) begin
        mx = pos_q[k];
      end
      box_wdata[k*POS_W +: POS_W]     = mn;
      box_wdata[(3+k)*POS_W +: POS_W] = mx;
    end
  end

  // Box memory: one read port, one write port
  assign box_addr = ctl.scan_read ? scan_b : map_rd;

  always_ff @(posedge clk) begin
    if (ctl.box_write) begin
      box_mem[map_rd] <= box_wdata;
    end
    if (ctl.box_read_add || ctl.scan_read) begin
      box_rd <= box_mem[box_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (ctl.touched_clear) begin
      touched <= '0;
    end else if (ctl.box_write) begin
      touched[map_rd] <= 1'b1;
    end
  end

  // Walk bone ids for finish
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      scan_b <= BONE_IW'(1);
    end else if (ctl.scan_step) begin
      scan_b <= scan_b + BONE_IW'(1);
    end
  end

  // Center and extent of the fetched box
  always_comb begin
    logic signed [POS_W:0] sum [3];
    logic signed [POS_W:0] diff [3];
    logic signed [POS_F_W-1:0] ctr [3];
    logic [EXT_W-1:0] ext [3];
    for (int k = 0; k < 3; k++) begin
      sum[k]  = (POS_W+1)'($signed(box_rd[k*POS_W +: POS_W]))
              + (POS_W+1)'($signed(box_rd[(3+k)*POS_W +: POS_W]));
      diff[k] = (POS_W+1)'($signed(box_rd[(3+k)*POS_W +: POS_W]))
              - (POS_W+1)'($signed(box_rd[k*POS_W +: POS_W]));
      ctr[k]  = POS_F_W'(sum[k] >>> 1);
      ext[k]  = EXT_W'($unsigned(diff[k]) >> 1);
    end
    fresh.out_bone = BONE_W'(scan_b);
    fresh.center_x = ctr[0];
    fresh.center_y = ctr[1];
    fresh.center_z = ctr[2];
    fresh.extent_x = ext[0];
    fresh.extent_y = ext[1];
    fresh.extent_z = ext[2];
    fresh.is_last  = 1'b0;
    fresh.is_empty = 1'b0;
  end

  // Last result of the run, or the empty marker
  always_comb begin
    final_res = '0;
    if (pend_v) begin
      final_res         = pend;
      final_res.is_last = 1'b1;
    end else begin
      final_res.is_last  = 1'b1;
      final_res.is_empty = 1'b1;
    end
  end

  // Pending result, held until the next one or the end of the walk is known
  always_ff @(posedge clk) begin
    if (ctl.pend_load) begin
      pend <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (ctl.scan_start || ctl.push_final) begin
      pend_v <= 1'b0;
    end else if (ctl.pend_load) begin
      pend_v <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((ctl.pend_load && pend_v) || ctl.push_final) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pend_load && pend_v) begin
      result <= pend;
    end else if (ctl.push_final) begin
      result <= final_res;
    end
  end

  // Status
  assign sts.add_ok   = map_hit_q;
  assign sts.scan_hit = touched[scan_b];
  assign sts.scan_end = (scan_b == BONE_IW'(BONE_SLOTS - 1));
  assign sts.out_free = !result_valid || result_ready;
  assign sts.pend_v   = pend_v;

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_empty |-> result.is_last && (result.out_bone == '0))
    else $error("empty result not marked last");

  a_no_bone_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_empty |-> (result.out_bone != '0))
    else $error("bone zero reported");

  a_clear_boxes: assert property (@(posedge clk) disable iff (rst)
    ctl.touched_clear |=> (touched == '0) && result_valid && result.is_last)
    else $error("finish left boxes or no last result");

endmodule

### hw/rtl/per_bone_bounds_accumulator_top.sv
// Add: accept with map read, box read, box write; the next item is taken once the
// add is done (after the map read if the influence is skipped). Set and clear are
// done on acceptance. Finish: walks bone ids 1..BONE_SLOTS-1, fetching the box of
// each touched bone, then flushes the last result; results leave through an output
// register, and a stalled receiver holds the walk until that register frees up.
// Reset (rst, synchronous) drops map entries, boxes and pending output.
module per_bone_bounds_accumulator_top #(
  parameter int BONE_SLOTS = pbba_pkg::BONE_SLOTS_DEF,
  parameter int MAP_SLOTS  = pbba_pkg::MAP_SLOTS_DEF,
  parameter int POS_BITS   = pbba_pkg::POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  pbba_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output pbba_pkg::result_t result
);
  import pbba_pkg::*;

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  pbba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_cmd   (item.cmd),
    .item_ready (item_ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  pbba_datapath #(
    .BONE_SLOTS (BONE_SLOTS),
    .MAP_SLOTS  (MAP_SLOTS),
    .POS_BITS   (POS_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
